// ===== hw/rtl/spl_pkg.sv =====
// Shared constants, codes and types for the slot pool with id lookup.
`default_nettype none

package spl_pkg;

    // Pool geometry
    localparam int SLOTS    = 64;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);

    // Field widths
    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 6;
    localparam int ID_W     = 32;
    localparam int STATUS_W = 2;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_CREATE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DESTROY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

    // Id counter value after reset
    localparam logic [ID_W-1:0] FIRST_ID = 32'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FREE,
        ST_SEARCH,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   slot;
        logic [ID_W-1:0]     lookup_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [ID_W-1:0]     id;
    } res_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [ID_W-1:0]  data;
    } ram_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spl_id_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module spl_id_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/spl_engine.sv =====
// Request sequencer: active marks, id counter, slot scans and result forming.
`default_nettype none

module spl_engine (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    input  wire spl_pkg::req_t              req,
    output logic                            req_ready,
    output logic                            resp_valid,
    output spl_pkg::res_t                   resp,
    output logic [spl_pkg::CNT_W-1:0]       resp_count,
    input  wire logic                       resp_take,
    output spl_pkg::ram_wr_t                ram_wr,
    output logic [spl_pkg::IDX_W-1:0]       ram_raddr,
    input  wire logic [spl_pkg::ID_W-1:0]   ram_rdata
);

    localparam logic [spl_pkg::IDX_W-1:0] LAST_IDX = spl_pkg::IDX_W'(spl_pkg::SLOTS - 1);

    spl_pkg::state_t                 state_reg, state_next;
    logic [spl_pkg::SLOTS-1:0]       active_reg, active_next;
    logic [spl_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [spl_pkg::ID_W-1:0]        next_id_reg, next_id_next;
    logic [spl_pkg::IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [spl_pkg::IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                            cmp_valid_reg, cmp_valid_next;
    logic [spl_pkg::ID_W-1:0]        want_reg, want_next;
    spl_pkg::res_t                   res_reg, res_next;

    logic                            accept;
    logic                            free_hit;
    logic                            scan_last;
    logic                            match;
    logic                            cmp_last;
    logic                            destroy_ok;
    logic [spl_pkg::IDX_W-1:0]       destroy_idx;

    // Scan conditions
    assign accept      = req_valid && (state_reg == spl_pkg::ST_IDLE);
    assign free_hit    = !active_reg[scan_idx_reg];
    assign scan_last   = (scan_idx_reg == LAST_IDX);
    assign match       = cmp_valid_reg && active_reg[cmp_idx_reg] && (ram_rdata == want_reg);
    assign cmp_last    = (cmp_idx_reg == LAST_IDX);
    assign destroy_ok  = (req.action == spl_pkg::ACT_DESTROY)
                         && (32'(req.slot) < 32'(spl_pkg::SLOTS));
    assign destroy_idx = spl_pkg::IDX_W'(req.slot);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spl_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.action == spl_pkg::ACT_CREATE)
                    begin
                        state_next = spl_pkg::ST_FREE;
                    end
                    else if (req.action == spl_pkg::ACT_LOOKUP)
                    begin
                        state_next = spl_pkg::ST_SEARCH;
                    end
                    else
                    begin
                        state_next = spl_pkg::ST_RESP;
                    end
                end
            end
            spl_pkg::ST_FREE:
            begin
                if (free_hit || scan_last)
                begin
                    state_next = spl_pkg::ST_RESP;
                end
            end
            spl_pkg::ST_SEARCH:
            begin
                if (match || (cmp_valid_reg && cmp_last))
                begin
                    state_next = spl_pkg::ST_RESP;
                end
            end
            spl_pkg::ST_RESP:
            begin
                if (resp_take)
                begin
                    state_next = spl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spl_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: handshake and RAM access
    always_comb
    begin
        req_ready    = 1'b0;
        resp_valid   = 1'b0;
        ram_wr.we    = 1'b0;
        ram_wr.addr  = scan_idx_reg;
        ram_wr.data  = next_id_reg;
        unique case (state_reg)
            spl_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid && destroy_ok)
                begin
                    ram_wr.we   = 1'b1;
                    ram_wr.addr = destroy_idx;
                    ram_wr.data = '0;
                end
            end
            spl_pkg::ST_FREE:
            begin
                ram_wr.we = free_hit;
            end
            spl_pkg::ST_SEARCH:
            begin
                ram_wr.we = 1'b0;
            end
            spl_pkg::ST_RESP:
            begin
                resp_valid = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign ram_raddr  = scan_idx_reg;
    assign resp       = res_reg;
    assign resp_count = count_reg;

    // Datapath next values
    always_comb
    begin
        active_next    = active_reg;
        count_next     = count_reg;
        next_id_next   = next_id_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        want_next      = want_reg;
        res_next       = res_reg;
        unique case (state_reg)
            spl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    want_next      = req.lookup_id;
                    scan_idx_next  = '0;
                    cmp_valid_next = 1'b0;
                    res_next       = '{status: spl_pkg::STAT_OK, slot: '0, id: '0};
                    if (destroy_ok)
                    begin
                        active_next[destroy_idx] = 1'b0;
                        if (active_reg[destroy_idx])
                        begin
                            count_next = count_reg - spl_pkg::CNT_W'(1);
                        end
                    end
                end
            end
            spl_pkg::ST_FREE:
            begin
                scan_idx_next = scan_idx_reg + spl_pkg::IDX_W'(1);
                if (free_hit)
                begin
                    active_next[scan_idx_reg] = 1'b1;
                    count_next   = count_reg + spl_pkg::CNT_W'(1);
                    next_id_next = next_id_reg + spl_pkg::ID_W'(1);
                    res_next     = '{status: spl_pkg::STAT_OK,
                                     slot: spl_pkg::SLOT_W'(scan_idx_reg),
                                     id: next_id_reg};
                end
                else if (scan_last)
                begin
                    res_next = '{status: spl_pkg::STAT_FULL, slot: '0, id: '0};
                end
            end
            spl_pkg::ST_SEARCH:
            begin
                // Issue one read a cycle, compare the previous read
                scan_idx_next  = scan_idx_reg + spl_pkg::IDX_W'(1);
                cmp_idx_next   = scan_idx_reg;
                cmp_valid_next = 1'b1;
                if (match)
                begin
                    res_next = '{status: spl_pkg::STAT_OK,
                                 slot: spl_pkg::SLOT_W'(cmp_idx_reg),
                                 id: ram_rdata};
                end
                else if (cmp_valid_reg && cmp_last)
                begin
                    res_next = '{status: spl_pkg::STAT_NOT_FOUND, slot: '0, id: '0};
                end
            end
            spl_pkg::ST_RESP:
            begin
                cmp_valid_next = 1'b0;
            end
            default:
            begin
                cmp_valid_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spl_pkg::ST_IDLE;
            active_reg    <= '0;
            count_reg     <= '0;
            next_id_reg   <= spl_pkg::FIRST_ID;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        want_reg     <= want_next;
        res_reg      <= res_next;
    end

    // The running count tracks the active marks
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(active_reg))
        else $error("active count out of step with active marks");

    // No id store writes while searching
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spl_pkg::ST_SEARCH) |-> !ram_wr.we)
        else $error("id store written during search");

    // A successful allocation bumps both the count and the id counter
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spl_pkg::ST_FREE && free_hit)
        |=> (count_reg == $past(count_reg) + spl_pkg::CNT_W'(1))
            && (next_id_reg == $past(next_id_reg) + spl_pkg::ID_W'(1)))
        else $error("allocation did not advance count and id");

    // A pending result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spl_pkg::ST_RESP && !resp_take)
        |=> (state_reg == spl_pkg::ST_RESP) && $stable(res_reg) && $stable(count_reg))
        else $error("pending result changed before it was taken");

endmodule

`default_nettype wire

// ===== hw/rtl/slot_pool_with_id_lookup_core.sv =====
// Slot pool with id lookup: a fixed pool of slots, each with an active mark and a 32-bit id.
//
// Usage: the input channel (in_valid / in_stall) carries one request per
// transaction: action create, destroy or look up, with slot (destroy) and
// lookup_id (look up). The output channel (out_valid / out_stall) returns
// exactly one result per request: status, result_slot, result_id and the
// active_count after the request, in request order.
// Timing: a request is taken only while the sequencer is idle. Destroy and
// the no-op code go straight to the result; create scans the active marks
// from slot 0 up to the lowest free slot, or through every slot when the
// pool is full; look up issues one id RAM read a cycle from slot 0 and
// compares each registered read of an active slot with lookup_id until the
// first match or the last slot. The next request is accepted only once the
// result has moved to the output register, so requests do not overlap; the
// slot scan sets the worst case.
// Reset: all slots go inactive, the count goes to 0 and the id counter to 1;
// the block accepts requests right after reset.
// Stall: a result waits in the output register while out_stall is high;
// the sequencer holds its next result, and in_stall stays high while it does.
`default_nettype none

module slot_pool_with_id_lookup_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [spl_pkg::ACTION_W-1:0]  action,
    input  wire logic [spl_pkg::SLOT_W-1:0]    slot,
    input  wire logic [spl_pkg::ID_W-1:0]      lookup_id,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [spl_pkg::STATUS_W-1:0]  status,
    output logic      [spl_pkg::SLOT_W-1:0]    result_slot,
    output logic      [spl_pkg::ID_W-1:0]      result_id,
    output logic      [spl_pkg::CNT_W-1:0]     active_count
);

    spl_pkg::req_t                   req;
    spl_pkg::res_t                   resp;
    logic [spl_pkg::CNT_W-1:0]       resp_count;
    logic                            req_ready;
    logic                            resp_valid;
    logic                            resp_take;
    spl_pkg::ram_wr_t                ram_wr;
    logic [spl_pkg::IDX_W-1:0]       ram_raddr;
    logic [spl_pkg::ID_W-1:0]        ram_rdata;

    logic                            out_valid_reg, out_valid_next;
    spl_pkg::res_t                   out_res_reg;
    logic [spl_pkg::CNT_W-1:0]       out_count_reg;

    assign req      = '{action: action, slot: slot, lookup_id: lookup_id};
    assign in_stall = !req_ready;

    spl_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (in_valid),
        .req        (req),
        .req_ready  (req_ready),
        .resp_valid (resp_valid),
        .resp       (resp),
        .resp_count (resp_count),
        .resp_take  (resp_take),
        .ram_wr     (ram_wr),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    spl_id_ram #(
        .DEPTH (spl_pkg::SLOTS),
        .WIDTH (spl_pkg::ID_W)
    ) u_id_ram (
        .clk   (clk),
        .we    (ram_wr.we),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Load the output register when it is empty or draining
    assign resp_take = resp_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (resp_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (resp_take)
        begin
            out_res_reg   <= resp;
            out_count_reg <= resp_count;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_res_reg.status;
    assign result_slot  = out_res_reg.slot;
    assign result_id    = out_res_reg.id;
    assign active_count = out_count_reg;

endmodule

`default_nettype wire

// ===== tb/sv/slot_pool_with_id_lookup_core_test.sv =====
// Self-checking testbench for the slot pool with id lookup core.
`default_nettype none

module slot_pool_with_id_lookup_core_test;
    import spl_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int STUCK_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 80;
    localparam int REPORT_MAX    = 10;
    localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [ID_W-1:0]     id;
        logic [CNT_W-1:0]    count;
    } pool_result_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;
    logic [ID_W-1:0]     lookup_id;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   result_slot;
    logic [ID_W-1:0]     result_id;
    logic [CNT_W-1:0]    active_count;

    // Shadow copy of the pool
    logic                live    [SLOTS];
    logic [ID_W-1:0]     live_id [SLOTS];
    logic [ID_W-1:0]     id_next;
    int                  live_total;

    pool_result_t        pool_replies_q[$];
    bit                  pacing;
    int                  mismatches;
    int                  checked;
    int                  n_create;
    int                  n_full;
    int                  n_destroy;
    int                  n_found;
    int                  n_missed;
    int                  n_nop;
    int                  peak_live;

    slot_pool_with_id_lookup_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .slot         (slot),
        .lookup_id    (lookup_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .result_slot  (result_slot),
        .result_id    (result_id),
        .active_count (active_count)
    );

    // Free-running clock
    always
    begin
        #CLK_HALF clk = ~clk;
    end

    // Apply one request to the shadow pool and return the result it owes
    function automatic pool_result_t pool_apply(input logic [ACTION_W-1:0] act,
                                                input logic [SLOT_W-1:0] idx,
                                                input logic [ID_W-1:0] want);
        pool_result_t r;
        int           hit;
        r   = '0;
        hit = -1;
        r.status = STAT_OK;
        if (act == ACT_CREATE)
        begin
            for (int i = SLOTS - 1; i >= 0; i--)
                if (!live[i])
                    hit = i;
            if (hit >= 0)
            begin
                live[hit]    = 1'b1;
                live_id[hit] = id_next;
                r.slot       = hit[SLOT_W-1:0];
                r.id         = id_next;
                id_next      = id_next + 1'b1;
                live_total++;
            end
            else
                r.status = STAT_FULL;
        end
        else if (act == ACT_DESTROY)
        begin
            if (live[idx])
                live_total--;
            live[idx]    = 1'b0;
            live_id[idx] = '0;
        end
        else if (act == ACT_LOOKUP)
        begin
            for (int i = SLOTS - 1; i >= 0; i--)
                if (live[i] && live_id[i] == want)
                    hit = i;
            if (hit >= 0)
            begin
                r.slot = hit[SLOT_W-1:0];
                r.id   = live_id[hit];
            end
            else
                r.status = STAT_NOT_FOUND;
        end
        r.count = live_total[CNT_W-1:0];
        return r;
    endfunction

    // Drive one request transaction, wait for it to be taken, queue its result
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] idx,
                             input logic [ID_W-1:0] want);
        pool_result_t r;
        if (pacing && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19) - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        action    <= act;
        slot      <= idx;
        lookup_id <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = pool_apply(act, idx, want);
        pool_replies_q.push_back(r);
        if (act == ACT_CREATE && r.status == STAT_FULL)
            n_full++;
        else if (act == ACT_CREATE)
            n_create++;
        else if (act == ACT_DESTROY)
            n_destroy++;
        else if (act == ACT_LOOKUP && r.status == STAT_OK)
            n_found++;
        else if (act == ACT_LOOKUP)
            n_missed++;
        else
            n_nop++;
        if (live_total > peak_live)
            peak_live = live_total;
    endtask

    // Pick a request with the given mix; aim destroys and lookups mostly at live slots
    task automatic send_random(input int create_pct, input int destroy_pct);
        int                  roll;
        int                  live_idx[$];
        logic [ACTION_W-1:0] act;
        logic [SLOT_W-1:0]   idx;
        logic [ID_W-1:0]     want;
        roll = $urandom_range(0, 99);
        idx  = SLOT_W'($urandom);
        want = $urandom;
        for (int i = 0; i < SLOTS; i++)
            if (live[i])
                live_idx.push_back(i);
        if (roll < 3)
            act = ACT_NOP;
        else if (roll < 3 + create_pct)
            act = ACT_CREATE;
        else if (roll < 3 + create_pct + destroy_pct)
        begin
            act = ACT_DESTROY;
            if (live_idx.size() != 0 && $urandom_range(0, 4) != 0)
                idx = SLOT_W'(live_idx[$urandom_range(0, live_idx.size() - 1)]);
        end
        else
        begin
            act = ACT_LOOKUP;
            if (live_idx.size() != 0 && $urandom_range(0, 3) != 0)
                want = live_id[live_idx[$urandom_range(0, live_idx.size() - 1)]];
            else if ($urandom_range(0, 2) == 0)
                want = id_next - $urandom_range(0, 3);
        end
        send_item(act, idx, want);
    endtask

    // Corner requests on a nearly empty pool
    task automatic test_directed();
        send_item(ACT_LOOKUP, 6'd0, 32'd1);
        send_item(ACT_CREATE, 6'h3F, 32'hFFFF_FFFF);
        send_item(ACT_CREATE, 6'd0, 32'd0);
        send_item(ACT_CREATE, 6'h2A, 32'h5555_5555);
        send_item(ACT_LOOKUP, 6'h3F, 32'd2);
        send_item(ACT_LOOKUP, 6'd0, 32'd0);
        send_item(ACT_LOOKUP, 6'd0, 32'hFFFF_FFFF);
        send_item(ACT_LOOKUP, 6'h15, 32'hAAAA_AAAA);
        send_item(ACT_DESTROY, 6'd1, 32'hFFFF_FFFF);
        send_item(ACT_LOOKUP, 6'd0, 32'd2);
        send_item(ACT_DESTROY, 6'd1, 32'd0);
        send_item(ACT_DESTROY, 6'h3F, 32'd0);
        send_item(ACT_NOP, 6'd0, 32'd0);
        send_item(ACT_NOP, 6'h3F, 32'hFFFF_FFFF);
        send_item(ACT_CREATE, 6'd5, 32'd3);
        send_item(ACT_LOOKUP, 6'd0, 32'd4);
        send_item(ACT_LOOKUP, 6'd0, 32'd1);
        send_item(ACT_DESTROY, 6'd0, 32'd1);
        send_item(ACT_LOOKUP, 6'd0, 32'd1);
        send_item(ACT_CREATE, 6'd0, 32'd0);
        send_item(ACT_LOOKUP, 6'd0, 32'd5);
    endtask

    // Fill the pool, run into the full case, punch holes at both ends and refill them
    task automatic test_pool_full();
        logic [ID_W-1:0] last_id;
        while (live_total < SLOTS)
            send_item(ACT_CREATE, SLOT_W'($urandom), $urandom);
        last_id = id_next - 1'b1;
        send_item(ACT_CREATE, SLOT_W'($urandom), $urandom);
        send_item(ACT_CREATE, SLOT_W'($urandom), $urandom);
        send_item(ACT_LOOKUP, SLOT_W'($urandom), last_id);
        send_item(ACT_DESTROY, 6'h3F, $urandom);
        send_item(ACT_DESTROY, 6'd0, $urandom);
        send_item(ACT_LOOKUP, SLOT_W'($urandom), last_id);
        send_item(ACT_CREATE, SLOT_W'($urandom), $urandom);
        send_item(ACT_CREATE, SLOT_W'($urandom), $urandom);
        send_item(ACT_CREATE, SLOT_W'($urandom), $urandom);
        send_item(ACT_NOP, SLOT_W'($urandom), $urandom);
    endtask

    // Sweep occupancy up and down with random traffic
    task automatic test_random_mix();
        repeat (200) send_random(20, 55);
        repeat (250) send_random(35, 30);
        repeat (150) send_random(60, 10);
        repeat (120) send_random(25, 45);
    endtask

    // Back-to-back traffic with both sides always ready
    task automatic test_no_idle();
        pacing = 1'b0;
        repeat (80) send_random(35, 30);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Stall the result channel in random bursts
    always
    begin
        @(negedge clk);
        if (pacing && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    // Compare each result transaction with the oldest one owed
    always @(posedge clk)
    begin
        pool_result_t want_r;
        if (rst_n && out_valid && !out_stall)
        begin
            checked++;
            if (pool_replies_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: status %0d slot %0d id %h count %0d",
                             status, result_slot, result_id, active_count);
            end
            else
            begin
                want_r = pool_replies_q.pop_front();
                if (status !== want_r.status || result_slot !== want_r.slot ||
                    result_id !== want_r.id || active_count !== want_r.count)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("result %0d: status %0d/%0d slot %0d/%0d id %h/%h count %0d/%0d (exp/got)",
                                 checked, want_r.status, status, want_r.slot, result_slot,
                                 want_r.id, result_id, want_r.count, active_count);
                end
            end
        end
    end

    // End the run if nothing moves on either channel for too long
    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ACT_CREATE;
        slot       = '0;
        lookup_id  = '0;
        out_stall  = 1'b0;
        pacing     = 1'b1;
        mismatches = 0;
        checked    = 0;
        n_create   = 0;
        n_full     = 0;
        n_destroy  = 0;
        n_found    = 0;
        n_missed   = 0;
        n_nop      = 0;
        peak_live  = 0;
        live_total = 0;
        id_next    = FIRST_ID;
        for (int i = 0; i < SLOTS; i++)
        begin
            live[i]    = 1'b0;
            live_id[i] = '0;
        end
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_pool_full();
        test_random_mix();
        test_no_idle();

        // Let the last results come back, then allow the longest scan to settle
        while (pool_replies_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatches += pool_replies_q.size();

        $display("covered %0d creates, %0d full-pool creates, %0d destroys, %0d no-ops",
                 n_create, n_full, n_destroy, n_nop);
        $display("lookups: %0d found, %0d not found; peak occupancy %0d of %0d; %0d results checked",
                 n_found, n_missed, peak_live, SLOTS, checked);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/spl_pkg.sv
hw/rtl/spl_id_ram.sv
hw/rtl/spl_engine.sv
hw/rtl/slot_pool_with_id_lookup_core.sv
tb/sv/slot_pool_with_id_lookup_core_test.sv
